/* rtl/rpps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpps_pkg
// Shared types, constants and helpers for the ratio priority process scheduler.
// ----------------------------------------------------------------------------
package rpps_pkg;

  localparam int SLOTS   = 18;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int SLOT_FW = 5;
  localparam int OP_W    = 2;
  localparam int CFG_IW  = 3;

  localparam logic [NS_W-1:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [NS_W:0]   NS_PER_SEC_1 = 31'd1000000000;
  localparam logic [NS_W:0]   NS_PER_SEC_2 = 31'd2000000000;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_QUANTUM = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BWAIT   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_IDLE    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_UNBLK   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_CREATE  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_BCOST   = 3'd5;

  localparam logic [NS_W-1:0] RST_QUANTUM = 30'd10000000;
  localparam logic [NS_W-1:0] RST_BWAIT   = 30'd600000000;
  localparam logic [NS_W-1:0] RST_IDLE    = 30'd100000;
  localparam logic [NS_W-1:0] RST_UNBLK   = 30'd3000;
  localparam logic [NS_W-1:0] RST_CREATE  = 30'd1000;
  localparam logic [NS_W-1:0] RST_BCOST   = 30'd5000;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_WAKE, S_SEL_CHK, S_E_GO, S_E_WT, S_S_GO, S_S_WT,
    S_AD_GO, S_AD_WT, S_CB_GO, S_CB_WT, S_NOSEL, S_REP_OVH, S_REP_USED,
    S_REP_END
  } state_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
  } tm_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_IW-1:0] idx;
  } free_t;

  // add nanoseconds and carry into seconds, a carry of up to two seconds
  function automatic tm_t tm_add(logic [SEC_W-1:0] sec, logic [NS_W-1:0] ns,
                                 logic [NS_W-1:0] add);
    logic [NS_W:0] sum;
    tm_t           r;
    sum = {1'b0, ns} + {1'b0, add};
    if (sum >= NS_PER_SEC_2) begin
      r.ns  = NS_W'(sum - NS_PER_SEC_2);
      r.sec = sec + 32'd2;
    end else if (sum >= NS_PER_SEC_1) begin
      r.ns  = NS_W'(sum - NS_PER_SEC_1);
      r.sec = sec + 32'd1;
    end else begin
      r.ns  = NS_W'(sum);
      r.sec = sec;
    end
    return r;
  endfunction

  function automatic free_t first_free(logic [SLOTS-1:0] busy);
    free_t r;
    r = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!busy[k]) begin
        r.found = 1'b1;
        r.idx   = SLOT_IW'(k);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/rpps_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpps_mul
// 64x64 to 128 bit multiplier built from one 32x32 multiplier over four steps.
// ----------------------------------------------------------------------------
module rpps_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rpps_pkg::mul_req_t req,
  output logic              done,
  output logic [127:0]      p
);
  import rpps_pkg::*;

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [2:0]   step_r;
  logic         run_r, ppv_r, done_r;
  logic [31:0]  ma, mb;

  always_comb begin
    case (step_r)
      3'd0:    begin ma = a_r[31:0];  mb = b_r[31:0];  end
      3'd1:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      3'd2:    begin ma = a_r[63:32]; mb = b_r[31:0];  end
      3'd3:    begin ma = a_r[63:32]; mb = b_r[63:32]; end
      default: begin ma = '0;         mb = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      run_r  <= 1'b1;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (run_r) begin
        if (step_r < 3'd4) begin
          ppv_r  <= 1'b1;
          step_r <= step_r + 3'd1;
        end else begin
          ppv_r  <= 1'b0;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else begin
      if (run_r && step_r < 3'd4) begin
        pp_r <= ma * mb;
        sh_r <= (step_r == 3'd0) ? 2'd0 : (step_r == 3'd3) ? 2'd2 : 2'd1;
      end
      if (ppv_r) begin
        acc_r <= acc_r + ({64'd0, pp_r} << {sh_r, 5'd0});
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

/* rtl/ratio_priority_process_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratio_priority_process_scheduler_top
// Process slot table with a seconds:nanoseconds clock and ratio based selection.
// ----------------------------------------------------------------------------
// One item is worked on at a time and produces one result. A create, or a
// report on a free slot, finishes in the dispatch step; a report on an occupied
// slot goes on through the overhead, used time and end steps. Wake and select
// first sweeps every slot to wake due blocked ones, then passes over each free
// or blocked slot, and for each ready slot passes the elapsed time, the service
// time and the two cross products of the ratio compare each through the shared
// 32x32 multiplier, which needs four partial products per 64x64 product. A
// finished result sits in the output register, so the next item can be taken
// while it waits.
module ratio_priority_process_scheduler_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rpps_pkg::OP_W-1:0]      in_op,
  input  logic [rpps_pkg::SLOT_FW-1:0]   in_slot,
  input  logic [rpps_pkg::NS_W-1:0]      in_time_used,
  input  logic                           in_terminated,
  input  logic [rpps_pkg::NS_W-1:0]      in_overhead_ns,
  input  logic [rpps_pkg::SEC_W-1:0]     in_jump_sec,
  input  logic [rpps_pkg::NS_W-1:0]      in_jump_ns,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rpps_pkg::SLOT_FW-1:0]   out_chosen_slot,
  output logic                           out_found,
  output logic [rpps_pkg::SEC_W-1:0]     out_now_sec,
  output logic [rpps_pkg::NS_W-1:0]      out_now_ns,
  input  logic                           cfg_we,
  input  logic [rpps_pkg::CFG_IW-1:0]    cfg_idx,
  input  logic [rpps_pkg::NS_W-1:0]      cfg_wdata
);
  import rpps_pkg::*;

  state_t state_r, state_nxt;

  logic [NS_W-1:0] quantum_r, bwait_r, idle_r, unblk_r, ccost_r, bcost_r;

  logic [SEC_W-1:0] clk_sec_r, clk_sec_nxt;
  logic [NS_W-1:0]  clk_ns_r, clk_ns_nxt;

  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic             blk_r [SLOTS];
  logic [SEC_W-1:0] st_sec_r [SLOTS];
  logic [NS_W-1:0]  st_ns_r [SLOTS];
  logic [SEC_W-1:0] sv_sec_r [SLOTS];
  logic [NS_W-1:0]  sv_ns_r [SLOTS];
  logic [SEC_W-1:0] wk_sec_r [SLOTS];
  logic [NS_W-1:0]  wk_ns_r [SLOTS];

  logic [OP_W-1:0]    op_r;
  logic [SLOT_FW-1:0] slot_r;
  logic [NS_W-1:0]    used_r, ovh_r, jns_r;
  logic               term_r;
  logic [SEC_W-1:0]   jsec_r;

  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [63:0]        e_r, e_nxt, s_r, s_nxt, bs_r, bs_nxt, be_r, be_nxt;
  logic [127:0]       p1_r, p1_nxt;
  logic               found_r, found_nxt;
  logic [SLOT_FW-1:0] chosen_r, chosen_nxt;

  logic               ov_r, ov_nxt;
  logic [SLOT_FW-1:0] oslot_r;
  logic               ofound_r;
  logic [SEC_W-1:0]   osec_r;
  logic [NS_W-1:0]    ons_r;

  mul_req_t     mreq;
  logic         mdone;
  logic [127:0] mp;

  logic               accept, last_i, slot_ok, due;
  logic [SLOT_IW-1:0] rd_idx, wr_idx;
  free_t              ff;
  tm_t                t_clk, t_sv, t_wk, t_jmp;
  logic [63:0]        a64;

  logic init_we, blk_we, blk_v, sv_we, wk_we;
  logic [SEC_W-1:0] sv_sec_nxt, wk_sec_nxt;
  logic [NS_W-1:0]  sv_ns_nxt, wk_ns_nxt;

  rpps_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mdone),
    .p    (mp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_i   = (i_r == CNT_W'(SLOTS - 1));
  assign slot_ok  = ({1'b0, slot_r} < 6'(SLOTS));
  assign ff       = first_free(busy_r);

  assign rd_idx = (state_r == S_DISP || state_r == S_REP_OVH || state_r == S_REP_USED ||
                   state_r == S_REP_END) ? slot_r[SLOT_IW-1:0] : i_r[SLOT_IW-1:0];
  assign wr_idx = (state_r == S_DISP && op_r == OP_CREATE) ? ff.idx : rd_idx;

  assign due = (clk_sec_r > wk_sec_r[rd_idx]) ||
               (clk_sec_r == wk_sec_r[rd_idx] && clk_ns_r >= wk_ns_r[rd_idx]);
  assign t_sv  = tm_add(sv_sec_r[rd_idx], sv_ns_r[rd_idx], used_r);
  assign t_wk  = tm_add(clk_sec_r, clk_ns_r, bwait_r);
  assign t_jmp = tm_add(jsec_r, '0, jns_r);
  assign a64   = mp[63:0] + {34'd0, clk_ns_r};

  // result goes out once the output register is free
  logic done_ev;
  always_comb begin
    done_ev = 1'b0;
    case (state_r)
      S_DISP:    done_ev = (op_r != OP_SELECT) &&
                           !(op_r == OP_REPORT && slot_ok && busy_r[rd_idx]);
      S_NOSEL:   done_ev = 1'b1;
      S_REP_END: done_ev = 1'b1;
      default:   done_ev = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (accept) state_nxt = S_DISP;
      S_DISP: begin
        if (op_r == OP_SELECT) state_nxt = S_WAKE;
        else if (op_r == OP_REPORT && slot_ok && busy_r[rd_idx]) state_nxt = S_REP_OVH;
        else state_nxt = S_IDLE;
      end
      S_WAKE:    if (last_i) state_nxt = S_SEL_CHK;
      S_SEL_CHK: begin
        if (busy_r[rd_idx] && !blk_r[rd_idx]) state_nxt = S_E_GO;
        else if (last_i) state_nxt = S_NOSEL;
      end
      S_E_GO:    state_nxt = S_E_WT;
      S_E_WT:    if (mdone) state_nxt = S_S_GO;
      S_S_GO:    state_nxt = S_S_WT;
      S_S_WT:    if (mdone) state_nxt = S_AD_GO;
      S_AD_GO:   state_nxt = S_AD_WT;
      S_AD_WT:   if (mdone) state_nxt = S_CB_GO;
      S_CB_GO:   state_nxt = S_CB_WT;
      S_CB_WT:   if (mdone) state_nxt = last_i ? S_NOSEL : S_SEL_CHK;
      S_NOSEL:   state_nxt = S_IDLE;
      S_REP_OVH: state_nxt = S_REP_USED;
      S_REP_USED: state_nxt = S_REP_END;
      S_REP_END: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
    // hold the last step while an earlier result still waits
    if (done_ev && ov_r && out_stall) state_nxt = state_r;
  end

  // datapath and table controls
  always_comb begin
    clk_sec_nxt = clk_sec_r;
    clk_ns_nxt  = clk_ns_r;
    busy_nxt    = busy_r;
    i_nxt       = i_r;
    e_nxt       = e_r;
    s_nxt       = s_r;
    bs_nxt      = bs_r;
    be_nxt      = be_r;
    p1_nxt      = p1_r;
    found_nxt   = found_r;
    chosen_nxt  = chosen_r;
    init_we     = 1'b0;
    blk_we      = 1'b0;
    blk_v       = 1'b0;
    sv_we       = 1'b0;
    wk_we       = 1'b0;
    sv_sec_nxt  = t_sv.sec;
    sv_ns_nxt   = t_sv.ns;
    wk_sec_nxt  = t_wk.sec;
    wk_ns_nxt   = t_wk.ns;
    mreq        = '0;
    t_clk       = '0;
    ov_nxt      = ov_r && out_stall;
    if (!(done_ev && ov_r && out_stall)) begin
      case (state_r)
        S_DISP: begin
          found_nxt  = 1'b0;
          chosen_nxt = '0;
          i_nxt      = '0;
          bs_nxt     = 64'd2;
          be_nxt     = 64'd1;
          if (op_r == OP_CREATE && ff.found) begin
            init_we         = 1'b1;
            busy_nxt[ff.idx] = 1'b1;
            t_clk       = tm_add(clk_sec_r, clk_ns_r, ccost_r);
            clk_sec_nxt = t_clk.sec;
            clk_ns_nxt  = t_clk.ns;
            found_nxt   = 1'b1;
            chosen_nxt  = SLOT_FW'(ff.idx);
          end
        end
        S_WAKE: begin
          if (busy_r[rd_idx] && blk_r[rd_idx] && due) begin
            blk_we      = 1'b1;
            blk_v       = 1'b0;
            t_clk       = tm_add(clk_sec_r, clk_ns_r, unblk_r);
            clk_sec_nxt = t_clk.sec;
            clk_ns_nxt  = t_clk.ns;
          end
          i_nxt = last_i ? '0 : i_r + CNT_W'(1);
        end
        S_SEL_CHK: begin
          if (!(busy_r[rd_idx] && !blk_r[rd_idx]) && !last_i) i_nxt = i_r + CNT_W'(1);
        end
        S_E_GO: begin
          mreq.start = 1'b1;
          mreq.a     = {32'd0, clk_sec_r - st_sec_r[rd_idx]};
          mreq.b     = {34'd0, NS_PER_SEC};
        end
        S_E_WT: begin
          if (mdone) e_nxt = (a64 < {34'd0, st_ns_r[rd_idx]}) ? 64'd0
                                                              : a64 - {34'd0, st_ns_r[rd_idx]};
        end
        S_S_GO: begin
          mreq.start = 1'b1;
          mreq.a     = {32'd0, sv_sec_r[rd_idx]};
          mreq.b     = {34'd0, NS_PER_SEC};
        end
        S_S_WT: begin
          if (mdone) begin
            // zero elapsed time counts as ratio zero
            if (e_r == 64'd0) begin
              s_nxt = 64'd0;
              e_nxt = 64'd1;
            end else begin
              s_nxt = mp[63:0] + {34'd0, sv_ns_r[rd_idx]};
            end
          end
        end
        S_AD_GO: begin
          mreq.start = 1'b1;
          mreq.a     = s_r;
          mreq.b     = be_r;
        end
        S_AD_WT: if (mdone) p1_nxt = mp;
        S_CB_GO: begin
          mreq.start = 1'b1;
          mreq.a     = bs_r;
          mreq.b     = e_r;
        end
        S_CB_WT: begin
          if (mdone) begin
            if (p1_r < mp) begin
              bs_nxt     = s_r;
              be_nxt     = e_r;
              found_nxt  = 1'b1;
              chosen_nxt = SLOT_FW'(rd_idx);
            end
            if (!last_i) i_nxt = i_r + CNT_W'(1);
          end
        end
        S_NOSEL: begin
          if (!found_r) begin
            if (|busy_r) begin
              t_clk       = tm_add(clk_sec_r, clk_ns_r, idle_r);
              clk_sec_nxt = t_clk.sec;
              clk_ns_nxt  = t_clk.ns;
            end else begin
              clk_sec_nxt = t_jmp.sec;
              clk_ns_nxt  = t_jmp.ns;
            end
          end
        end
        S_REP_OVH: begin
          t_clk       = tm_add(clk_sec_r, clk_ns_r, ovh_r);
          clk_sec_nxt = t_clk.sec;
          clk_ns_nxt  = t_clk.ns;
          sv_we       = 1'b1;
        end
        S_REP_USED: begin
          t_clk       = tm_add(clk_sec_r, clk_ns_r, used_r);
          clk_sec_nxt = t_clk.sec;
          clk_ns_nxt  = t_clk.ns;
        end
        S_REP_END: begin
          if (term_r) begin
            busy_nxt[rd_idx] = 1'b0;
          end else if (used_r != quantum_r) begin
            blk_we      = 1'b1;
            blk_v       = 1'b1;
            wk_we       = 1'b1;
            t_clk       = tm_add(clk_sec_r, clk_ns_r, bcost_r);
            clk_sec_nxt = t_clk.sec;
            clk_ns_nxt  = t_clk.ns;
          end
        end
        default: ;
      endcase
      if (done_ev) ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clk_sec_r <= '0;
      clk_ns_r  <= '0;
      busy_r    <= '0;
      ov_r      <= 1'b0;
      quantum_r <= RST_QUANTUM;
      bwait_r   <= RST_BWAIT;
      idle_r    <= RST_IDLE;
      unblk_r   <= RST_UNBLK;
      ccost_r   <= RST_CREATE;
      bcost_r   <= RST_BCOST;
    end else begin
      state_r   <= state_nxt;
      clk_sec_r <= clk_sec_nxt;
      clk_ns_r  <= clk_ns_nxt;
      busy_r    <= busy_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_QUANTUM: quantum_r <= cfg_wdata;
          CFG_BWAIT:   bwait_r   <= cfg_wdata;
          CFG_IDLE:    idle_r    <= cfg_wdata;
          CFG_UNBLK:   unblk_r   <= cfg_wdata;
          CFG_CREATE:  ccost_r   <= cfg_wdata;
          CFG_BCOST:   bcost_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      slot_r <= in_slot;
      used_r <= in_time_used;
      term_r <= in_terminated;
      ovh_r  <= in_overhead_ns;
      jsec_r <= in_jump_sec;
      jns_r  <= in_jump_ns;
    end
    i_r      <= i_nxt;
    e_r      <= e_nxt;
    s_r      <= s_nxt;
    bs_r     <= bs_nxt;
    be_r     <= be_nxt;
    p1_r     <= p1_nxt;
    found_r  <= found_nxt;
    chosen_r <= chosen_nxt;
    if (init_we) begin
      blk_r[wr_idx]    <= 1'b0;
      st_sec_r[wr_idx] <= clk_sec_r;
      st_ns_r[wr_idx]  <= clk_ns_r;
      sv_sec_r[wr_idx] <= '0;
      sv_ns_r[wr_idx]  <= '0;
      wk_sec_r[wr_idx] <= '0;
      wk_ns_r[wr_idx]  <= '0;
    end
    if (blk_we) blk_r[wr_idx] <= blk_v;
    if (sv_we) begin
      sv_sec_r[wr_idx] <= sv_sec_nxt;
      sv_ns_r[wr_idx]  <= sv_ns_nxt;
    end
    if (wk_we) begin
      wk_sec_r[wr_idx] <= wk_sec_nxt;
      wk_ns_r[wr_idx]  <= wk_ns_nxt;
    end
    // output register loads from the values this last step leaves
    if (done_ev && !(ov_r && out_stall)) begin
      oslot_r  <= (state_r == S_DISP) ? chosen_nxt : chosen_r;
      ofound_r <= (state_r == S_DISP) ? found_nxt : found_r;
      osec_r   <= clk_sec_nxt;
      ons_r    <= clk_ns_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_chosen_slot = oslot_r;
  assign out_found       = ofound_r;
  assign out_now_sec     = osec_r;
  assign out_now_ns      = ons_r;

endmodule

/* rtl/rpps_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpps_chk
// Port level checks for the ratio priority process scheduler.
// ----------------------------------------------------------------------------
module rpps_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rpps_pkg::SLOT_FW-1:0] out_chosen_slot,
  input logic                         out_found,
  input logic [rpps_pkg::NS_W-1:0]    out_now_ns
);
  import rpps_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_chosen_slot == '0)
    else $error("slot reported without a find");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> {1'b0, out_chosen_slot} < 6'(SLOTS))
    else $error("chosen slot out of range");

  a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_now_ns < NS_PER_SEC)
    else $error("nanoseconds not normalized");

endmodule

bind ratio_priority_process_scheduler_top rpps_chk u_rpps_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_chosen_slot(out_chosen_slot),
  .out_found      (out_found),
  .out_now_ns     (out_now_ns)
);
